### sv/stack_blur_line_rgba8_defines.svh
// Assertion macros for the stack blur line filter.
`ifndef STACK_BLUR_LINE_RGBA8_DEFINES_SVH
`define STACK_BLUR_LINE_RGBA8_DEFINES_SVH

// Check in the next cycle, outside reset.
`define SBL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stack blur assertion failed");

// Check the cycle after reset.
`define SBL_ASSERT_RESET(lbl, clk, rst, cons) \
   lbl: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("stack blur reset assertion failed");

`endif

### sv/sbl_pkg.sv
// Types and constants shared by the stack blur line filter.
package sbl_pkg;

   localparam int CHAN_W  = 8;
   localparam int PIXEL_W = 4 * CHAN_W;
   localparam int WSUM_W  = 24;
   localparam int HSUM_W  = 16;
   localparam int MULT_W  = 16;
   localparam int SHIFT_W = 5;
   localparam int RAD_W   = 8;
   localparam int RSQ_W   = 16;
   localparam int LPOS_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MULT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHIFT  = 2'd2;

   localparam logic [RAD_W-1:0]   RADIUS_RESET = 8'd1;
   localparam logic [MULT_W-1:0]  MULT_RESET   = 16'd512;
   localparam logic [SHIFT_W-1:0] SHIFT_RESET  = 5'd11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD,
      ST_FILL,
      ST_MUL,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic upd;
      logic start;
      logic mul;
   } lane_ctl_type;

endpackage

### sv/sbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 509
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/sbl_lane.sv
// One color channel lane: running sums and output scaling.
module sbl_lane (
   input  logic                         clock,
   input  logic                         reset,
   input  sbl_pkg::lane_ctl_type        ctl,
   input  logic [sbl_pkg::CHAN_W-1:0]   in_chan,
   input  logic [sbl_pkg::CHAN_W-1:0]   old_chan,
   input  logic [sbl_pkg::CHAN_W-1:0]   ctr_chan,
   input  logic [sbl_pkg::RAD_W-1:0]    radius,
   input  logic [sbl_pkg::RSQ_W-1:0]    radius_sq,
   input  logic [sbl_pkg::MULT_W-1:0]   mult,
   input  logic [sbl_pkg::SHIFT_W-1:0]  shift,
   output logic [sbl_pkg::CHAN_W-1:0]   result
);
   import sbl_pkg::*;

   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [HSUM_W-1:0] isum_ff, isum_in;
   logic [HSUM_W-1:0] osum_ff, osum_in;
   logic [CHAN_W-1:0] res_ff, res_in;
   logic [WSUM_W+MULT_W-1:0] prod;
   logic [31:0] prod_lo;

   always_comb begin
      wsum_in = wsum_ff;
      isum_in = isum_ff;
      osum_in = osum_ff;
      if (ctl.upd) begin
         if (ctl.start) begin
            wsum_in = WSUM_W'(in_chan) * WSUM_W'(radius_sq);
            osum_in = HSUM_W'(in_chan) * (HSUM_W'(radius) + HSUM_W'(1));
            isum_in = HSUM_W'(in_chan) * HSUM_W'(radius);
         end else begin
            wsum_in = wsum_ff - WSUM_W'(osum_ff) + WSUM_W'(isum_ff) + WSUM_W'(in_chan);
            osum_in = osum_ff - HSUM_W'(old_chan) + HSUM_W'(ctr_chan);
            isum_in = isum_ff - HSUM_W'(ctr_chan) + HSUM_W'(in_chan);
         end
      end
      prod    = wsum_ff * mult;
      prod_lo = prod[31:0];
      res_in  = ctl.mul ? CHAN_W'(prod_lo >> shift) : res_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff <= '0;
         isum_ff <= '0;
         osum_ff <= '0;
      end else begin
         wsum_ff <= wsum_in;
         isum_ff <= isum_in;
         osum_ff <= osum_in;
      end
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

### sv/stack_blur_line_rgba8.sv
// Stack blur over one line of RGBA8 pixels, four channel lanes and a merged result register.
// Steps per accepted pixel: ring read, sum update, scaling multiply, result load; a line
// start first fills the ring, and a full result register holds the load until rsp_ready.
// A new pixel is taken only once the last is through; after a radius write the read pointer
// drops by one ring size per cycle until it lies in the ring, and requests wait meanwhile.
// Reset: synchronous; clears the sums, pointers, line position, last pixel and control state.
module stack_blur_line_rgba8 #(
   parameter int MAX_RADIUS = 254
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [sbl_pkg::CHAN_W-1:0]        req_in_red,
   input  logic [sbl_pkg::CHAN_W-1:0]        req_in_green,
   input  logic [sbl_pkg::CHAN_W-1:0]        req_in_blue,
   input  logic [sbl_pkg::CHAN_W-1:0]        req_in_alpha,
   input  logic                              req_line_start,
   input  logic                              req_pad,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [sbl_pkg::CHAN_W-1:0]        rsp_out_red,
   output logic [sbl_pkg::CHAN_W-1:0]        rsp_out_green,
   output logic [sbl_pkg::CHAN_W-1:0]        rsp_out_blue,
   output logic [sbl_pkg::CHAN_W-1:0]        rsp_out_alpha,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [sbl_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sbl_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sbl_pkg::*;

   localparam int DEPTH = 2 * MAX_RADIUS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = CW + 2;

   state_type state_ff, state_in;

   logic [RAD_W-1:0]   radius_ff;
   logic [MULT_W-1:0]  mult_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [RSQ_W-1:0]   rsq_ff;

   logic [RAD_W-1:0]   r_eff;
   logic [CW-1:0]      div_w;
   logic [SW-1:0]      ctr_sum;
   logic [AW-1:0]      ctr_addr;

   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [AW-1:0]      red_ff, red_in;
   logic [AW-1:0]      fill_ff, fill_in;
   logic [LPOS_W-1:0]  lpos_ff, lpos_in;
   logic [PIXEL_W-1:0] last_ff, last_in;
   logic [PIXEL_W-1:0] px_ff, px_in;
   logic               start_ff, start_in;
   logic               emit_ff, emit_in;

   logic [PIXEL_W-1:0] old_px, ctr_px;
   logic [AW-1:0]      ring_addr;
   logic               ring_we;

   logic               out_full_ff, out_full_in;
   logic [PIXEL_W-1:0] out_ff, out_in;
   logic [PIXEL_W-1:0] lane_res;
   logic               load;
   lane_ctl_type       ctl;

   always_comb begin
      priority if (radius_ff == '0) begin
         r_eff = 8'd1;
      end else if (radius_ff > RAD_W'(MAX_RADIUS)) begin
         r_eff = RAD_W'(MAX_RADIUS);
      end else begin
         r_eff = radius_ff;
      end
      div_w   = CW'({r_eff, 1'b1});
      ctr_sum = SW'(red_ff) + SW'(r_eff) + SW'(1);
      if (ctr_sum >= SW'(div_w)) begin
         ctr_sum = ctr_sum - SW'(div_w);
      end
      ctr_addr = AW'(ctr_sum);
   end

   assign csr_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RADIUS_RESET;
         mult_ff   <= MULT_RESET;
         shift_ff  <= SHIFT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RADIUS: radius_ff <= RAD_W'(csr_data);
            CSR_MULT:   mult_ff   <= csr_data;
            CSR_SHIFT:  shift_ff  <= SHIFT_W'(csr_data);
            default: ;
         endcase
      end
      rsq_ff <= (RSQ_W'(r_eff) + RSQ_W'(1)) * (RSQ_W'(r_eff) + RSQ_W'(1));
   end

   sbl_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH)) u_ring_old (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_addr),
      .wr_data (px_ff),
      .rd_addr (red_ff),
      .rd_data (old_px)
   );

   sbl_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH)) u_ring_ctr (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (ring_addr),
      .wr_data (px_ff),
      .rd_addr (ctr_addr),
      .rd_data (ctr_px)
   );

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      ring_we     = 1'b0;
      ring_addr   = red_ff;
      load        = 1'b0;
      ctl         = '0;
      px_in       = px_ff;
      start_in    = start_ff;
      last_in     = last_ff;
      ptr_in      = ptr_ff;
      red_in      = red_ff;
      fill_in     = fill_ff;
      lpos_in     = lpos_ff;
      emit_in     = emit_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !csr_valid && (CW'(red_ff) < div_w);
            if (csr_valid && csr_index == CSR_RADIUS) begin
               red_in = ptr_ff;
            end else if (CW'(red_ff) >= div_w) begin
               red_in = red_ff - AW'(div_w);
            end
            if (req_valid && req_ready) begin
               start_in = req_line_start;
               if (req_pad) begin
                  px_in = last_ff;
               end else begin
                  px_in   = {req_in_alpha, req_in_blue, req_in_green, req_in_red};
                  last_in = px_in;
               end
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            ctl.upd   = 1'b1;
            ctl.start = start_ff;
            if (start_ff) begin
               ptr_in   = '0;
               red_in   = '0;
               fill_in  = '0;
               lpos_in  = '0;
               state_in = ST_FILL;
            end else begin
               ring_we  = 1'b1;
               ptr_in   = (CW'(red_ff) + CW'(1) >= div_w) ? '0 : red_ff + AW'(1);
               red_in   = ptr_in;
               lpos_in  = (lpos_ff == '1) ? lpos_ff : lpos_ff + LPOS_W'(1);
               state_in = ST_MUL;
            end
            emit_in = lpos_in >= LPOS_W'(r_eff);
         end
         ST_FILL: begin
            ring_we   = 1'b1;
            ring_addr = fill_ff;
            if (CW'(fill_ff) + CW'(1) >= div_w) begin
               fill_in  = '0;
               state_in = ST_MUL;
            end else begin
               fill_in = fill_ff + AW'(1);
            end
         end
         ST_MUL: begin
            ctl.mul  = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!emit_ff) begin
               state_in = ST_IDLE;
            end else if (!out_full_ff || rsp_ready) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   for (genvar c = 0; c < 4; c++) begin : g_lane
      sbl_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .in_chan   (px_ff[c*CHAN_W +: CHAN_W]),
         .old_chan  (old_px[c*CHAN_W +: CHAN_W]),
         .ctr_chan  (ctr_px[c*CHAN_W +: CHAN_W]),
         .radius    (r_eff),
         .radius_sq (rsq_ff),
         .mult      (mult_ff),
         .shift     (shift_ff),
         .result    (lane_res[c*CHAN_W +: CHAN_W])
      );
   end

   assign out_full_in = (out_full_ff && !rsp_ready) || load;
   assign out_in      = load ? lane_res : out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         ptr_ff      <= '0;
         red_ff      <= '0;
         fill_ff     <= '0;
         lpos_ff     <= '0;
         last_ff     <= '0;
         start_ff    <= 1'b0;
         emit_ff     <= 1'b0;
         out_full_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ptr_ff      <= ptr_in;
         red_ff      <= red_in;
         fill_ff     <= fill_in;
         lpos_ff     <= lpos_in;
         last_ff     <= last_in;
         start_ff    <= start_in;
         emit_ff     <= emit_in;
         out_full_ff <= out_full_in;
      end
      px_ff       <= px_in;
      out_ff      <= out_in;
   end

   assign rsp_valid     = out_full_ff;
   assign rsp_out_red   = out_ff[0*CHAN_W +: CHAN_W];
   assign rsp_out_green = out_ff[1*CHAN_W +: CHAN_W];
   assign rsp_out_blue  = out_ff[2*CHAN_W +: CHAN_W];
   assign rsp_out_alpha = out_ff[3*CHAN_W +: CHAN_W];

endmodule

### sv/sbl_checker.sv
// Port-level checks for the stack blur line filter, bound to the top level.
`include "stack_blur_line_rgba8_defines.svh"

module sbl_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        csr_ready,
   input logic [sbl_pkg::PIXEL_W-1:0] rsp_data
);

   `SBL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `SBL_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data))
   `SBL_ASSERT_NEXT(a_req_busy, clock, reset, req_valid && req_ready, !req_ready)
   `SBL_ASSERT_RESET(a_reset_empty, clock, reset, !rsp_valid && csr_ready)

endmodule

bind stack_blur_line_rgba8 sbl_checker u_sbl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .csr_ready (csr_ready),
   .rsp_data  ({rsp_out_alpha, rsp_out_blue, rsp_out_green, rsp_out_red})
);

### tb/sv/tb_top.sv
// Self-checking testbench for the stack blur line filter with its own line predictor.
`timescale 1ns / 100ps

module tb_top;
   import sbl_pkg::*;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
   } blur_px_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_in_red = '0;
   logic [7:0] req_in_green = '0;
   logic [7:0] req_in_blue = '0;
   logic [7:0] req_in_alpha = '0;
   logic req_line_start = 1'b0;
   logic req_pad = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic [7:0] rsp_out_alpha;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   stack_blur_line_rgba8 u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // line filter predictor state
   logic [31:0] px_ring[509];
   logic [23:0] wt_sum[4];
   logic [15:0] in_sum[4];
   logic [15:0] out_sum[4];
   int unsigned ring_ptr;
   int unsigned line_pos;
   logic [31:0] last_px;
   logic [7:0] cfg_radius;
   logic [15:0] cfg_mult;
   logic [4:0] cfg_shift;

   blur_px_type blurred_q[$];
   int errors = 0;
   int items_sent = 0;
   int burst_left = 0;

   function automatic int unsigned eff_radius();
      if (cfg_radius == 0) return 1;
      if (cfg_radius > 254) return 254;
      return cfg_radius;
   endfunction

   function automatic void predict_blur(input logic [31:0] pix, input bit ls, input bit pd);
      int unsigned rad;
      int unsigned span;
      int unsigned ptr;
      int unsigned v, o, m;
      logic [31:0] px, oldest, centre, prod;
      logic [7:0] res[4];
      rad = eff_radius();
      span = 2 * rad + 1;
      if (pd) px = last_px;
      else begin
         px = pix;
         last_px = pix;
      end
      if (ls) begin
         for (int i = 0; i < span; i++) px_ring[i] = px;
         for (int c = 0; c < 4; c++) begin
            v = px[8*c +: 8];
            wt_sum[c] = 24'(v * (rad + 1) * (rad + 1));
            out_sum[c] = 16'(v * (rad + 1));
            in_sum[c] = 16'(v * rad);
         end
         ring_ptr = 0;
         line_pos = 0;
      end else begin
         ptr = ring_ptr % span;
         oldest = px_ring[ptr];
         centre = px_ring[(ptr + rad + 1) % span];
         for (int c = 0; c < 4; c++) begin
            v = px[8*c +: 8];
            o = oldest[8*c +: 8];
            m = centre[8*c +: 8];
            wt_sum[c] = 24'(wt_sum[c] - out_sum[c] + in_sum[c] + v);
            out_sum[c] = 16'(out_sum[c] - o + m);
            in_sum[c] = 16'(in_sum[c] - m + v);
         end
         px_ring[ptr] = px;
         ptr++;
         if (ptr >= span) ptr = 0;
         ring_ptr = ptr;
         if (line_pos < 511) line_pos++;
      end
      if (line_pos < rad) return;
      for (int c = 0; c < 4; c++) begin
         prod = 32'(wt_sum[c]) * 32'(cfg_mult);
         res[c] = 8'(prod >> cfg_shift);
      end
      blurred_q.push_back('{red: res[0], green: res[1], blue: res[2], alpha: res[3]});
   endfunction

   task automatic report(input string what, input int got, input int want);
      $display("tb: mismatch %s got %0h want %0h", what, got, want);
      errors++;
   endtask

   // hold valid until the transaction is accepted
   task automatic send_pixel(input logic [31:0] pix, input bit ls, input bit pd);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_in_red <= pix[7:0];
      req_in_green <= pix[15:8];
      req_in_blue <= pix[23:16];
      req_in_alpha <= pix[31:24];
      req_line_start <= ls;
      req_pad <= pd;
      do @(posedge clock); while (!req_ready);
      predict_blur(pix, ls, pd);
      items_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_RADIUS: cfg_radius = value[7:0];
         CSR_MULT: cfg_mult = value[15:0];
         CSR_SHIFT: cfg_shift = value[4:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (blurred_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic program_blur(input int rad, input int mult, input int shift);
      drain();
      write_reg(CSR_RADIUS, rad);
      write_reg(CSR_MULT, mult);
      write_reg(CSR_SHIFT, shift);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_line(input int width, input bit noisy);
      int unsigned rad;
      rad = eff_radius();
      send_pixel($urandom, 1'b1, noisy && $urandom_range(0, 3) == 0);
      for (int i = 1; i < width; i++)
         send_pixel($urandom, 1'b0, noisy && $urandom_range(0, 5) == 0);
      for (int i = 0; i < rad; i++) send_pixel($urandom, 1'b0, 1'b1);
   endtask

   task automatic test_directed();
      send_pixel(32'h0000_0000, 1'b1, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_pixel(32'hAA55_AA55, 1'b0, 1'b0);
      send_pixel(32'h55AA_55AA, 1'b0, 1'b0);
      send_pixel(32'h0000_0000, 1'b0, 1'b1);
      send_pixel(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_pixel(32'h0000_0000, 1'b0, 1'b1);
      send_pixel(32'h1234_5678, 1'b1, 1'b1);
      send_pixel(32'h8001_FF7F, 1'b0, 1'b0);
      send_pixel(32'h0, 1'b0, 1'b1);
      send_pixel(32'hFF00_00FF, 1'b1, 1'b0);
      send_pixel(32'h0, 1'b0, 1'b1);
   endtask

   task automatic test_config_extremes();
      program_blur(254, 1, 0);
      send_line(3, 1'b0);
      program_blur(0, 65535, 0);
      send_line(6, 1'b0);
      program_blur(255, 65535, 31);
      send_line(2, 1'b0);
      program_blur(2, 65535, 16);
      send_line(600, 1'b0);
      program_blur(1, 1, 31);
      send_line(8, 1'b0);
   endtask

   task automatic test_random_lines();
      int rad;
      while (items_sent < 1200) begin
         rad = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 8);
         program_blur(rad, $urandom_range(1, 65535), $urandom_range(0, 31));
         repeat ($urandom_range(1, 6))
            send_line($urandom_range(1, 40), $urandom_range(0, 4) == 0);
      end
   endtask

   // check each result and stall the result channel in changing patterns
   int stall_mode = 0;
   int stall_left = 0;
   always @(posedge clock) begin
      blur_px_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blurred_q.size() == 0) report("unexpected result", 0, 0);
         else begin
            want = blurred_q.pop_front();
            if (rsp_out_red !== want.red) report("red", rsp_out_red, want.red);
            if (rsp_out_green !== want.green) report("green", rsp_out_green, want.green);
            if (rsp_out_blue !== want.blue) report("blue", rsp_out_blue, want.blue);
            if (rsp_out_alpha !== want.alpha) report("alpha", rsp_out_alpha, want.alpha);
         end
      end
      if (stall_left == 0) begin
         stall_left = $urandom_range(20, 300);
         stall_mode = $urandom_range(0, 3);
      end
      stall_left--;
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 7) == 0);
         default: rsp_ready <= (stall_left % 5) != 0;
      endcase
   end

   initial begin
      cfg_radius = RADIUS_RESET;
      cfg_mult = MULT_RESET;
      cfg_shift = SHIFT_RESET;
      for (int i = 0; i < 509; i++) px_ring[i] = '0;
      for (int c = 0; c < 4; c++) begin
         wt_sum[c] = '0;
         in_sum[c] = '0;
         out_sum[c] = '0;
      end
      ring_ptr = 0;
      line_pos = 0;
      last_px = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_config_extremes();
      test_random_lines();
      drain();
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
